@@ hdl/pid_integral_separation_macros.svh @@
// Assertion macros used by the checker of the PID block.
`ifndef PID_INTEGRAL_SEPARATION_MACROS_SVH
`define PID_INTEGRAL_SEPARATION_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define PIDIS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("PID block assertion failed");

// Next-cycle implication, off while reset is high.
`define PIDIS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("PID block assertion failed");

// Next-cycle implication that is also checked across reset.
`define PIDIS_ASSERT_NXT_RAW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("PID block assertion failed");

`endif

@@ hdl/pidis_pkg.sv @@
// Package with widths, constants and types of the PID block.
`timescale 1ns / 1ps
`default_nettype none
package pidis_pkg;

   localparam int DATA_W      = 16;
   localparam int ERR_W       = DATA_W + 1;
   localparam int DIFF_W      = ERR_W + 1;
   localparam int SUM_W       = 20;
   localparam int GAIN_W      = 16;
   localparam int GAIN_S_W    = GAIN_W + 1;
   localparam int PROD_P_W    = GAIN_S_W + ERR_W;
   localparam int PROD_I_W    = GAIN_S_W + SUM_W;
   localparam int PROD_D_W    = GAIN_S_W + DIFF_W;
   localparam int ACC_W       = PROD_I_W + 1;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int unsigned DEFAULT_GAIN_FRAC_BITS = 8;
   localparam int unsigned DEFAULT_SUM_LIMIT      = 300000;

   localparam logic [DATA_W-1:0] DRIVE_UPPER_RESET = 16'sd1000;
   localparam logic [DATA_W-1:0] DRIVE_LOWER_RESET = -16'sd1000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_GAIN_P      = 3'd0,
      REG_GAIN_I      = 3'd1,
      REG_GAIN_D      = 3'd2,
      REG_SEP_LIMIT   = 3'd3,
      REG_DRIVE_UPPER = 3'd4,
      REG_DRIVE_LOWER = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_i;
      logic [GAIN_W-1:0] gain_d;
      logic [GAIN_W-1:0] separation_limit;
      logic [DATA_W-1:0] drive_upper;
      logic [DATA_W-1:0] drive_lower;
   } cfg_type;

   typedef struct packed {
      logic [PROD_P_W-1:0] prod_p;
      logic [PROD_I_W-1:0] prod_i;
      logic [PROD_D_W-1:0] prod_d;
   } terms_type;

endpackage
`default_nettype wire

@@ hdl/pidis_regs.sv @@
// Configuration registers of the PID block.
`timescale 1ns / 1ps
`default_nettype none
module pidis_regs (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write,
   input  wire logic [pidis_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [pidis_pkg::CSR_DATA_W-1:0]   csr_data,
   output pidis_pkg::cfg_type                      cfg
);
   import pidis_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_GAIN_P:      cfg_in.gain_p           = csr_data;
            REG_GAIN_I:      cfg_in.gain_i           = csr_data;
            REG_GAIN_D:      cfg_in.gain_d           = csr_data;
            REG_SEP_LIMIT:   cfg_in.separation_limit = csr_data;
            REG_DRIVE_UPPER: cfg_in.drive_upper      = csr_data;
            REG_DRIVE_LOWER: cfg_in.drive_lower      = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p           <= '0;
         cfg_ff.gain_i           <= '0;
         cfg_ff.gain_d           <= '0;
         cfg_ff.separation_limit <= '0;
         cfg_ff.drive_upper      <= DRIVE_UPPER_RESET;
         cfg_ff.drive_lower      <= DRIVE_LOWER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ hdl/pidis_terms.sv @@
// Input register, error and integral state, and the three gain products.
`timescale 1ns / 1ps
`default_nettype none
module pidis_terms #(
   parameter int unsigned SUM_LIMIT = pidis_pkg::DEFAULT_SUM_LIMIT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pidis_pkg::cfg_type            cfg,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [pidis_pkg::DATA_W-1:0]  req_setpoint,
   input  wire logic [pidis_pkg::DATA_W-1:0]  req_measured,
   input  wire logic                          terms_ready,
   output logic                               terms_valid,
   output pidis_pkg::terms_type               terms
);
   import pidis_pkg::*;

   localparam logic signed [SUM_W:0] SumMax = (SUM_W + 1)'(SUM_LIMIT);
   localparam logic signed [SUM_W:0] SumMin = -SumMax;

   logic                      in_valid_ff;
   logic                      in_valid_in;
   logic [DATA_W-1:0]         setpoint_ff;
   logic [DATA_W-1:0]         measured_ff;
   logic signed [ERR_W-1:0]   last_error_ff;
   logic signed [ERR_W-1:0]   last_error_in;
   logic signed [SUM_W-1:0]   error_sum_ff;
   logic signed [SUM_W-1:0]   error_sum_in;
   logic                      terms_valid_ff;
   logic                      terms_valid_in;
   terms_type                 terms_ff;
   terms_type                 terms_in;

   logic                      req_accept;
   logic                      in_advance;
   logic signed [ERR_W-1:0]   err;
   logic [ERR_W-1:0]          err_mag;
   logic                      integrate;
   logic signed [SUM_W:0]     sum_wide;
   logic signed [SUM_W:0]     sum_pick;
   logic signed [DIFF_W-1:0]  err_diff;
   logic signed [GAIN_S_W-1:0] gain_p_s;
   logic signed [GAIN_S_W-1:0] gain_i_s;
   logic signed [GAIN_S_W-1:0] gain_d_s;

   assign in_advance     = in_valid_ff && (!terms_valid_ff || terms_ready);
   assign req_stall      = in_valid_ff && !in_advance;
   assign req_accept     = req_valid && !req_stall;
   assign in_valid_in    = req_accept ? 1'b1 : (in_advance ? 1'b0 : in_valid_ff);
   assign terms_valid_in = in_advance ? 1'b1 : (terms_ready ? 1'b0 : terms_valid_ff);

   always_comb begin
      err      = ERR_W'($signed(setpoint_ff)) - ERR_W'($signed(measured_ff));
      err_mag  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
      integrate = (cfg.gain_i != '0) &&
                  ((cfg.separation_limit == '0) ||
                   (err_mag < {1'b0, cfg.separation_limit}));
      sum_wide = (SUM_W + 1)'(error_sum_ff) + (SUM_W + 1)'(err);
      sum_pick = integrate ? sum_wide : '0;
      if (sum_pick > SumMax) begin
         sum_pick = SumMax;
      end
      if (sum_pick < SumMin) begin
         sum_pick = SumMin;
      end
      error_sum_in  = SUM_W'(sum_pick);
      last_error_in = err;
      err_diff      = DIFF_W'(err) - DIFF_W'(last_error_ff);

      gain_p_s = $signed({1'b0, cfg.gain_p});
      gain_i_s = $signed({1'b0, cfg.gain_i});
      gain_d_s = $signed({1'b0, cfg.gain_d});

      terms_in.prod_p = PROD_P_W'(gain_p_s) * PROD_P_W'(err);
      terms_in.prod_i = PROD_I_W'(gain_i_s) * PROD_I_W'(error_sum_in);
      terms_in.prod_d = PROD_D_W'(gain_d_s) * PROD_D_W'(err_diff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         terms_valid_ff <= 1'b0;
         last_error_ff  <= '0;
         error_sum_ff   <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         terms_valid_ff <= terms_valid_in;
         if (in_advance) begin
            last_error_ff <= last_error_in;
            error_sum_ff  <= error_sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         setpoint_ff <= req_setpoint;
         measured_ff <= req_measured;
      end
      if (in_advance) begin
         terms_ff <= terms_in;
      end
   end

   assign terms_valid = terms_valid_ff;
   assign terms       = terms_ff;

endmodule
`default_nettype wire

@@ hdl/pidis_drive.sv @@
// Sum of the gain products, fraction shift, saturation and result register.
`timescale 1ns / 1ps
`default_nettype none
module pidis_drive #(
   parameter int unsigned GAIN_FRAC_BITS = pidis_pkg::DEFAULT_GAIN_FRAC_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pidis_pkg::cfg_type            cfg,
   input  wire logic                          terms_valid,
   input  wire pidis_pkg::terms_type          terms,
   output logic                               terms_ready,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [pidis_pkg::DATA_W-1:0]       rsp_drive
);
   import pidis_pkg::*;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [DATA_W-1:0]        drive_ff;
   logic [DATA_W-1:0]        drive_in;
   logic                     load;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  scaled;
   logic signed [ACC_W-1:0]  upper_w;
   logic signed [ACC_W-1:0]  lower_w;
   logic signed [ACC_W-1:0]  bounded;

   assign terms_ready  = !rsp_valid_ff || !rsp_stall;
   assign load         = terms_valid && terms_ready;
   assign rsp_valid_in = load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_comb begin
      acc = ACC_W'($signed(terms.prod_p)) + ACC_W'($signed(terms.prod_i)) +
            ACC_W'($signed(terms.prod_d));
      scaled  = acc >>> GAIN_FRAC_BITS;
      upper_w = ACC_W'($signed(cfg.drive_upper));
      lower_w = ACC_W'($signed(cfg.drive_lower));
      bounded = scaled;
      if (bounded > upper_w) begin
         bounded = upper_w;
      end
      if (bounded < lower_w) begin
         bounded = lower_w;
      end
      drive_in = bounded[DATA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         drive_ff <= drive_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = drive_ff;

endmodule
`default_nettype wire

@@ hdl/pid_integral_separation.sv @@
// Integral and last error are updated as a beat leaves the input stage.
// Throughput: one beat per cycle while rsp_stall is low.
// Pipeline: input register, gain product register, then the result register.
// Reset is synchronous and active high: it empties the pipeline, clears the
// integral and last error, zeroes the gains and sets the drive bounds to +/-1000.
`timescale 1ns / 1ps
`default_nettype none
module pid_integral_separation #(
   parameter int unsigned GAIN_FRAC_BITS = pidis_pkg::DEFAULT_GAIN_FRAC_BITS,
   parameter int unsigned SUM_LIMIT      = pidis_pkg::DEFAULT_SUM_LIMIT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [pidis_pkg::DATA_W-1:0]       req_setpoint,
   input  wire logic [pidis_pkg::DATA_W-1:0]       req_measured,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [pidis_pkg::DATA_W-1:0]            rsp_drive,
   input  wire logic                               csr_write,
   input  wire logic [pidis_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [pidis_pkg::CSR_DATA_W-1:0]   csr_data
);
   import pidis_pkg::*;

   cfg_type   cfg;
   terms_type terms;
   logic      terms_valid;
   logic      terms_ready;

   pidis_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pidis_terms #(
      .SUM_LIMIT (SUM_LIMIT)
   ) u_terms (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_setpoint (req_setpoint),
      .req_measured (req_measured),
      .terms_ready  (terms_ready),
      .terms_valid  (terms_valid),
      .terms        (terms)
   );

   pidis_drive #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_drive (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .terms_valid (terms_valid),
      .terms       (terms),
      .terms_ready (terms_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_drive   (rsp_drive)
   );

endmodule
`default_nettype wire

@@ hdl/pidis_checker.sv @@
// Port-level checker of the PID block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "pid_integral_separation_macros.svh"
module pidis_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall
);

   // The pipeline never holds back an input beat while the output side drains.
   `PIDIS_ASSERT_IMP(a_no_stall_when_drained, !rsp_stall, !req_stall)

   // A reset leaves no result beat behind.
   `PIDIS_ASSERT_NXT_RAW(a_reset_empties, reset, !rsp_valid)

   // An accepted beat passes the input, gain product and result registers to the output when nothing stalls.
   `PIDIS_ASSERT_NXT(a_latency, (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall, rsp_valid)

   // A stalled result beat stays offered.
   `PIDIS_ASSERT_NXT(a_rsp_holds, rsp_valid && rsp_stall, rsp_valid)

endmodule

bind pid_integral_separation pidis_checker u_checker (.*);
`default_nettype wire

@@ tb/tb_pid_integral_separation.sv @@
// Self-checking testbench for the PID step block with integral separation.
`timescale 1ns / 1ps
module tb_pid_integral_separation;
   import pidis_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] setpoint;
      logic [DATA_W-1:0] measured;
   } pid_step_type;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int LATENCY = 3;
   localparam int FRAC_BITS = DEFAULT_GAIN_FRAC_BITS;
   localparam longint SUM_CLAMP = longint'(DEFAULT_SUM_LIMIT);
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
   localparam logic [DATA_W-1:0] MAX_POS = 16'h7FFF;
   localparam logic [DATA_W-1:0] MAX_NEG = 16'h8000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [DATA_W-1:0] req_setpoint = '0;
   logic [DATA_W-1:0] req_measured = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [DATA_W-1:0] rsp_drive;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic [GAIN_W-1:0] kp = '0;
   logic [GAIN_W-1:0] ki = '0;
   logic [GAIN_W-1:0] kd = '0;
   logic [GAIN_W-1:0] sep_limit = '0;
   logic signed [DATA_W-1:0] drive_hi = DRIVE_UPPER_RESET;
   logic signed [DATA_W-1:0] drive_lo = DRIVE_LOWER_RESET;
   logic signed [ERR_W-1:0] prev_error = '0;
   logic signed [SUM_W-1:0] error_integral = '0;

   pid_step_type pending_steps[$];
   logic [DATA_W-1:0] expected_drives[$];
   int unsigned steps_queued = 0;
   int unsigned drives_seen = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int send_gap_pct = 34;
   int stall_pct = 34;
   logic req_taken = 1'b0;

   pid_integral_separation dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_setpoint(req_setpoint),
      .req_measured(req_measured),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_drive(rsp_drive),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   function automatic logic [DATA_W-1:0] predict_drive(logic signed [DATA_W-1:0] sp,
         logic signed [DATA_W-1:0] ms);
      longint err;
      longint mag;
      longint sum;
      longint acc;
      longint drv;
      err = longint'(sp) - longint'(ms);
      mag = (err < 0) ? -err : err;
      sum = longint'(error_integral);
      if (ki == '0) begin
         sum = 0;
      end else if (sep_limit == '0 || mag < longint'(sep_limit)) begin
         sum = sum + err;
      end else begin
         sum = 0;
      end
      if (sum > SUM_CLAMP) sum = SUM_CLAMP;
      if (sum < -SUM_CLAMP) sum = -SUM_CLAMP;
      acc = longint'(kp) * err + longint'(ki) * sum
         + longint'(kd) * (err - longint'(prev_error));
      drv = acc >>> FRAC_BITS;
      if (drv > longint'(drive_hi)) drv = longint'(drive_hi);
      if (drv < longint'(drive_lo)) drv = longint'(drive_lo);
      error_integral = sum[SUM_W-1:0];
      prev_error = err[ERR_W-1:0];
      return drv[DATA_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            expected_drives.push_back(predict_drive(req_setpoint, req_measured));
         end
      end
   end

   always @(negedge clock) begin
      pid_step_type next_step;
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_steps.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
            next_step = pending_steps.pop_front();
            req_valid <= 1'b1;
            req_setpoint <= next_step.setpoint;
            req_measured <= next_step.measured;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      logic [DATA_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_drives.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("Unexpected drive beat %0d at cycle %0d",
                        $signed(rsp_drive), cycle_count);
            end
         end else begin
            want = expected_drives.pop_front();
            drives_seen++;
            if (rsp_drive !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Drive mismatch at cycle %0d: expected %0d, got %0d",
                           cycle_count, $signed(want), $signed(rsp_drive));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("** pid_integral_separation: FAILED **");
         $finish;
      end
   end

   task automatic add_step(input logic [DATA_W-1:0] sp, input logic [DATA_W-1:0] ms);
      pid_step_type s;
      s.setpoint = sp;
      s.measured = ms;
      pending_steps.push_back(s);
      steps_queued++;
   endtask

   task automatic wait_quiet();
      do @(negedge clock); while (drives_seen != steps_queued);
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
         input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         REG_GAIN_P: kp = val;
         REG_GAIN_I: ki = val;
         REG_GAIN_D: kd = val;
         REG_SEP_LIMIT: sep_limit = val;
         REG_DRIVE_UPPER: drive_hi = val;
         REG_DRIVE_LOWER: drive_lo = val;
         default: ;
      endcase
   endtask

   task automatic program_settings(input logic [15:0] p, input logic [15:0] i,
         input logic [15:0] d, input logic [15:0] sep, input logic [15:0] hi,
         input logic [15:0] lo, input bit spare);
      wait_quiet();
      write_reg(REG_GAIN_P, p);
      write_reg(REG_GAIN_I, i);
      write_reg(REG_GAIN_D, d);
      write_reg(REG_SEP_LIMIT, sep);
      write_reg(REG_DRIVE_UPPER, hi);
      write_reg(REG_DRIVE_LOWER, lo);
      if (spare) begin
         write_reg(REG_SPARE_LO, 16'($urandom));
         write_reg(REG_SPARE_HI, 16'($urandom));
      end
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [15:0] pick_gain();
      int unsigned r;
      r = $urandom_range(9);
      if (r < 2) return '0;
      if (r == 2) return 16'hFFFF;
      if (r < 8) return 16'($urandom_range(600));
      return 16'($urandom);
   endfunction

   task automatic random_phase(input int count);
      logic [15:0] sep;
      logic [15:0] hi;
      logic [15:0] lo;
      int unsigned r;
      int span;
      int sp;
      int ms;
      r = $urandom_range(9);
      if (r < 3) sep = '0;
      else if (r < 7) sep = 16'($urandom_range(2000, 1));
      else if (r < 9) sep = 16'($urandom);
      else sep = 16'hFFFF;
      r = $urandom_range(9);
      if (r < 6) begin
         hi = 16'($urandom_range(32767));
         lo = 16'(-int'($urandom_range(32768)));
      end else if (r < 8) begin
         hi = MAX_POS;
         lo = MAX_NEG;
      end else begin
         hi = 16'($urandom);
         lo = 16'($urandom);
      end
      program_settings(pick_gain(), pick_gain(), pick_gain(), sep, hi, lo,
                       $urandom_range(2) == 0);
      span = (sep != '0 && sep < 16'd30000) ? int'(sep) + 2 : 400;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         sp = int'($urandom_range(65535)) - 32768;
         if (r < 50) begin
            ms = sp - (int'($urandom_range(2 * span)) - span);
            if (ms > 32767) ms = 32767;
            if (ms < -32768) ms = -32768;
         end else if (r < 85) begin
            ms = int'($urandom_range(65535)) - 32768;
         end else begin
            sp = ($urandom_range(1) == 0) ? 32767 : -32768;
            ms = ($urandom_range(1) == 0) ? -sp - 1 : int'($urandom_range(65535)) - 32768;
         end
         add_step(16'(sp), 16'(ms));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_step(MAX_POS, MAX_NEG);
      add_step(MAX_NEG, MAX_POS);

      program_settings(16'h0100, '0, '0, '0, MAX_POS, MAX_NEG, 1'b0);
      add_step(MAX_POS, MAX_NEG);
      add_step(MAX_NEG, MAX_POS);

      program_settings(16'd1, '0, '0, '0, MAX_POS, MAX_NEG, 1'b0);
      add_step(16'd0, 16'd1);
      add_step(16'd0, 16'd255);
      add_step(16'd0, 16'd256);
      add_step(16'd0, 16'd257);
      add_step(16'd255, 16'd0);

      program_settings('0, 16'h0100, '0, 16'd100, MAX_POS, MAX_NEG, 1'b1);
      add_step(16'd99, 16'd0);
      add_step(16'd50, 16'd0);
      add_step(16'd100, 16'd0);
      add_step(16'd0, 16'd99);
      add_step(16'd0, 16'd100);

      program_settings('0, 16'd1, '0, '0, MAX_POS, MAX_NEG, 1'b0);
      repeat (5) add_step(MAX_POS, MAX_NEG);
      add_step(MAX_NEG, MAX_POS);

      program_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFF9C, 16'd100, 1'b0);
      add_step(MAX_POS, MAX_NEG);
      add_step(MAX_NEG, MAX_POS);

      for (int ph = 0; ph < 14; ph++) begin
         wait_quiet();
         send_gap_pct = (ph == 6) ? 0 : 34;
         stall_pct = (ph == 6) ? 0 : 34;
         random_phase(50);
      end

      wait_quiet();
      repeat (4 * LATENCY) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** pid_integral_separation: PASSED **");
      end else begin
         $display("** pid_integral_separation: FAILED **");
      end
      $finish;
   end

endmodule

@@ pid_integral_separation.f @@
+incdir+hdl
hdl/pidis_pkg.sv
hdl/pidis_regs.sv
hdl/pidis_terms.sv
hdl/pidis_drive.sv
hdl/pid_integral_separation.sv
hdl/pidis_checker.sv
tb/tb_pid_integral_separation.sv
